// ===== rtl/tttc_pkg.sv =====
package tttc_pkg;

   localparam int COORD_BITS_DEF  = 12;
   localparam int HEIGHT_BITS_DEF = 13;
   localparam int TIME_BITS       = 32;

   // exp2 fraction step constants r_i, 30 fraction bits
   localparam int RT_BITS = 32;
   typedef logic [RT_BITS-1:0] root_array_type [1:16];

   function automatic logic [63:0] isqrt_c(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res  = 64'd0;
      rem  = v;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (bitv > v) bitv = bitv >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   function automatic root_array_type make_roots();
      root_array_type t;
      logic [63:0] r;
      r = isqrt_c(64'd1 << 61);
      for (int i = 1; i <= 16; i++) begin
         t[i] = r[RT_BITS-1:0];
         r = isqrt_c(r << 30);
      end
      return t;
   endfunction

   localparam root_array_type ROOTS = make_roots();

   // control flags carried down the pipe
   typedef struct packed {
      logic no_move;
      logic sat;
   } flags_type;

endpackage

// ===== rtl/tttc_sqrt_stage.sv =====
// One stage of a bit-pair restoring square root: handles STEPS result bits.
module tttc_sqrt_stage #(
   parameter int RW    = 32,
   parameter int STEPS = 2
) (
   input  logic [2*RW-1:0] rad_in,
   input  logic [RW-1:0]   root_in,
   input  logic [RW+1:0]   rem_in,
   output logic [2*RW-1:0] rad_out,
   output logic [RW-1:0]   root_out,
   output logic [RW+1:0]   rem_out
);
   always_comb begin
      logic [RW+1:0] rem;
      logic [RW+1:0] trial;
      logic [RW-1:0] root;
      logic [2*RW-1:0] rad;
      rem  = rem_in;
      root = root_in;
      rad  = rad_in;
      for (int k = 0; k < STEPS; k++) begin
         rem   = {rem[RW-1:0], rad[2*RW-1:2*RW-2]};
         rad   = {rad[2*RW-3:0], 2'b00};
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[RW-2:0], 1'b1};
         end else begin
            root = {root[RW-2:0], 1'b0};
         end
      end
      rad_out  = rad;
      root_out = root;
      rem_out  = rem;
   end
endmodule

// ===== rtl/tttc_sqrt_pipe.sv =====
// Pipelined integer square root, STEPS result bits per register stage.
module tttc_sqrt_pipe #(
   parameter int RW    = 32,
   parameter int STEPS = 2
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-1:0] rad,
   output logic [RW-1:0]   root
);
   localparam int NST = (RW + STEPS - 1) / STEPS;

   logic [2*RW-1:0] rad_ff  [0:NST];
   logic [RW-1:0]   root_ff [0:NST];
   logic [RW+1:0]   rem_ff  [0:NST];

   always_comb begin
      rad_ff[0]  = rad;
      root_ff[0] = '0;
      rem_ff[0]  = '0;
   end

   for (genvar g = 0; g < NST; g++) begin : g_st
      logic [2*RW-1:0] rad_in;
      logic [RW-1:0]   root_in;
      logic [RW+1:0]   rem_in;
      localparam int NS = ((g + 1) * STEPS > RW) ? (RW - g * STEPS) : STEPS;
      tttc_sqrt_stage #(.RW(RW), .STEPS(NS)) u_st (
         .rad_in(rad_ff[g]), .root_in(root_ff[g]), .rem_in(rem_ff[g]),
         .rad_out(rad_in), .root_out(root_in), .rem_out(rem_in)
      );
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[g+1]  <= rad_in;
            root_ff[g+1] <= root_in;
            rem_ff[g+1]  <= rem_in;
         end
      end
   end

   assign root = root_ff[NST];
endmodule

// ===== rtl/tttc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tttc_div_pipe #(
   parameter int NW = 40,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);
   logic [NW-1:0] q_ff [0:NW];
   logic [DW:0]   r_ff [0:NW];
   logic [DW-1:0] d_ff [0:NW];

   always_comb begin
      q_ff[0] = num;
      r_ff[0] = '0;
      d_ff[0] = den;
   end

   for (genvar g = 0; g < NW; g++) begin : g_st
      logic [DW+1:0] sh;
      logic [DW+1:0] df;
      assign sh = {r_ff[g], q_ff[g][NW-1]};
      assign df = sh - {2'b00, d_ff[g]};
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[g+1] <= d_ff[g];
            if (!df[DW+1]) begin
               r_ff[g+1] <= df[DW:0];
               q_ff[g+1] <= {q_ff[g][NW-2:0], 1'b1};
            end else begin
               r_ff[g+1] <= sh[DW:0];
               q_ff[g+1] <= {q_ff[g][NW-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = q_ff[NW];
endmodule

// ===== rtl/terrain_travel_time_cost.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    from_x/height/z, to_x/height/z
// rsp_      out        rsp_valid/stall    travel_time, no_movement, saturated
//
// One transaction enters per cycle unless rsp_ stalls; the pipeline depth is
// set by the two square roots (2 bits a stage), the slope divider (1 bit a
// stage), a chain of exp2 multiplies (one per stage) and a split 3/5 scaling.
// Reset clears only the stage valid bits.
// A stall on rsp_ freezes the whole pipe when the last stage holds a valid
// result; req_stall follows it then.
module terrain_travel_time_cost #(
   parameter int COORD_BITS  = tttc_pkg::COORD_BITS_DEF,
   parameter int HEIGHT_BITS = tttc_pkg::HEIGHT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COORD_BITS-1:0]     req_from_x,
   input  logic [HEIGHT_BITS-1:0]    req_from_height,
   input  logic [COORD_BITS-1:0]     req_from_z,
   input  logic [COORD_BITS-1:0]     req_to_x,
   input  logic [HEIGHT_BITS-1:0]    req_to_height,
   input  logic [COORD_BITS-1:0]     req_to_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [tttc_pkg::TIME_BITS-1:0] rsp_travel_time,
   output logic                      rsp_no_movement,
   output logic                      rsp_saturated
);
   import tttc_pkg::*;

   localparam int MB  = (COORD_BITS > HEIGHT_BITS) ? COORD_BITS : HEIGHT_BITS;
   localparam int FF  = ((60 - 2 * MB) / 2 > 16) ? 16 : (60 - 2 * MB) / 2;
   localparam int FB  = (FF < 0) ? 0 : FF;
   // root width; the 64-bit radicand fits the squared distance for MB up to 31
   localparam int RW  = 32;
   localparam int DXW = COORD_BITS;
   localparam int DHW = HEIGHT_BITS;
   localparam int SQRT_ST = RW / 2;
   // divider: num = |20*dh*2^F + Hq| * 57344 fits in NW bits
   localparam int NW  = 64;
   localparam int DW  = RW + 3;
   localparam int LAT = 1 + SQRT_ST + NW + 2 + 16 + 4;

   // global enable: whole pipe advances unless the output is held
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   logic v_ff [0:LAT];
   always_comb v_ff[0] = req_valid;
   for (genvar g = 0; g < LAT; g++) begin : g_v
      always_ff @(posedge clock) begin
         if (reset) v_ff[g+1] <= 1'b0;
         else if (en) v_ff[g+1] <= v_ff[g];
      end
   end
   assign rsp_valid = v_ff[LAT];

   // stage 1: differences and squares
   logic [DXW-1:0]      dx_in, dz_in;
   logic [DHW-1:0]      adh_in;
   logic                neg_in;
   logic [63:0]         h2_ff, d2_ff;
   logic [DHW-1:0]      adh_ff;
   logic                neg_ff;
   always_comb begin
      dx_in  = (req_from_x > req_to_x) ? req_from_x - req_to_x : req_to_x - req_from_x;
      dz_in  = (req_from_z > req_to_z) ? req_from_z - req_to_z : req_to_z - req_from_z;
      neg_in = req_from_height > req_to_height;
      adh_in = neg_in ? req_from_height - req_to_height : req_to_height - req_from_height;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         h2_ff  <= (64'(dx_in) * 64'(dx_in) + 64'(dz_in) * 64'(dz_in)) << (2 * FB);
         d2_ff  <= (64'(dx_in) * 64'(dx_in) + 64'(dz_in) * 64'(dz_in)
                   + 64'(adh_in) * 64'(adh_in)) << (2 * FB);
         adh_ff <= adh_in;
         neg_ff <= neg_in;
      end
   end

   // square roots
   logic [RW-1:0] hq_w, dq_w;
   tttc_sqrt_pipe #(.RW(RW), .STEPS(2)) u_hq (.clock(clock), .en(en), .rad(h2_ff),
      .root(hq_w));
   tttc_sqrt_pipe #(.RW(RW), .STEPS(2)) u_dq (.clock(clock), .en(en), .rad(d2_ff),
      .root(dq_w));

   logic [DHW-1:0] adh_d [0:SQRT_ST];
   logic           neg_d [0:SQRT_ST];
   always_comb begin
      adh_d[0] = adh_ff;
      neg_d[0] = neg_ff;
   end
   for (genvar g = 0; g < SQRT_ST; g++) begin : g_sd
      always_ff @(posedge clock) begin
         if (en) begin
            adh_d[g+1] <= adh_d[g];
            neg_d[g+1] <= neg_d[g];
         end
      end
   end

   // numerator of slope term, then divider
   logic [63:0]   sdh, snum, num_in;
   logic [DW-1:0] den_in;
   always_comb begin
      sdh = (64'(adh_d[SQRT_ST]) * 64'd20) << FB;
      if (!neg_d[SQRT_ST])         snum = sdh + 64'(hq_w);
      else if (sdh >= 64'(hq_w))   snum = sdh - 64'(hq_w);
      else                         snum = 64'(hq_w) - sdh;
      num_in = snum * 64'd57344;
      den_in = DW'(hq_w) * DW'(5);
   end

   logic [63:0] a_w;
   tttc_div_pipe #(.NW(NW), .DW(DW)) u_div (.clock(clock), .en(en), .num(num_in),
      .den(den_in), .quo(a_w));

   logic [RW-1:0] dq_d [0:NW];
   logic          nm_d [0:NW];
   always_comb begin
      dq_d[0] = dq_w;
      nm_d[0] = (hq_w == '0);
   end
   for (genvar g = 0; g < NW; g++) begin : g_dd
      always_ff @(posedge clock) begin
         if (en) begin
            dq_d[g+1] <= dq_d[g];
            nm_d[g+1] <= nm_d[g];
         end
      end
   end

   // exponent scale by log2(e)
   logic [RW-1:0] dq_p1, dq_p2;
   flags_type     fl_p1, fl_p2;
   logic [47:0]   pr_ff;
   logic [63:0]   a_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff        <= a_w;
         dq_p1       <= dq_d[NW];
         fl_p1.no_move <= nm_d[NW];
         fl_p1.sat   <= (a_w >= (64'd18 << 16)) && !nm_d[NW];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= 48'((64'(a_ff[20:0]) * 64'd94548) >> 16);
         dq_p2 <= dq_p1;
         fl_p2 <= fl_p1;
      end
   end

   // exp2 of fraction: one conditional multiply per stage
   logic [31:0]   m_d  [0:16];
   logic [15:0]   f_d  [0:16];
   logic [5:0]    n_d  [0:16];
   logic [RW-1:0] dq_e [0:16];
   flags_type     fl_e [0:16];
   always_comb begin
      m_d[0]  = 32'd1 << 30;
      f_d[0]  = pr_ff[15:0];
      n_d[0]  = pr_ff[21:16];
      dq_e[0] = dq_p2;
      fl_e[0] = fl_p2;
   end
   for (genvar g = 0; g < 16; g++) begin : g_ex
      logic [63:0] prod;
      assign prod = (64'(m_d[g]) * 64'(ROOTS[g+1])) >> 30;
      always_ff @(posedge clock) begin
         if (en) begin
            m_d[g+1]  <= f_d[g][15-g] ? prod[31:0] : m_d[g];
            f_d[g+1]  <= f_d[g];
            n_d[g+1]  <= n_d[g];
            dq_e[g+1] <= dq_e[g];
            fl_e[g+1] <= fl_e[g];
         end
      end
   end

   // y = floor(3*x/5): x*3 times ceil(2^66/5), taken as four 32x32 partial
   // products in one stage and summed in the next
   localparam logic [31:0] RCP5_LO = 32'hCCCC_CCCD;
   localparam logic [31:0] RCP5_HI = 32'hCCCC_CCCC;
   logic [63:0]  x_ff, y_ff;
   logic [63:0]  pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [5:0]   n_x, n_p, n_y;
   flags_type    fl_x, fl_p, fl_y;
   logic [63:0]  x3;
   logic [127:0] qm;
   always_comb begin
      x3 = x_ff * 64'd3;
      qm = {pp_hh_ff, 64'd0} + {32'd0, pp_lh_ff, 32'd0} + {32'd0, pp_hl_ff, 32'd0}
           + {64'd0, pp_ll_ff};
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= 64'(dq_e[16]) * 64'(m_d[16]);
         n_x      <= n_d[16];
         fl_x     <= fl_e[16];
         pp_ll_ff <= 64'(x3[31:0]) * 64'(RCP5_LO);
         pp_lh_ff <= 64'(x3[31:0]) * 64'(RCP5_HI);
         pp_hl_ff <= 64'(x3[63:32]) * 64'(RCP5_LO);
         pp_hh_ff <= 64'(x3[63:32]) * 64'(RCP5_HI);
         n_p      <= n_x;
         fl_p     <= fl_x;
         y_ff     <= 64'(qm[127:66]);
         n_y      <= n_p;
         fl_y     <= fl_p;
      end
   end

   // final shift and saturation
   logic signed [7:0] s;
   logic [63:0]       t;
   logic              ov;
   always_comb begin
      s  = $signed({2'b00, n_y}) - 8'(FB + 22);
      t  = '0;
      ov = 1'b0;
      if (s >= 0) begin
         if (s >= 32) ov = (y_ff != 0) || 1'b1;
         else begin
            t  = y_ff << s;
            ov = (y_ff >> (32 - s)) != 0;
         end
      end else begin
         t  = y_ff >> (-s);
         ov = t[63:32] != 0;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_no_movement <= fl_y.no_move;
         if (fl_y.no_move) begin
            rsp_travel_time <= '0;
            rsp_saturated   <= 1'b0;
         end else if (fl_y.sat || ov) begin
            rsp_travel_time <= '1;
            rsp_saturated   <= 1'b1;
         end else begin
            rsp_travel_time <= t[31:0];
            rsp_saturated   <= 1'b0;
         end
      end
   end
endmodule

// ===== tb/sv/terrain_travel_time_cost_checker.sv =====
`timescale 1ns / 100ps

module terrain_travel_time_cost_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [11:0] req_from_x,
   input  logic [12:0] req_from_height,
   input  logic [11:0] req_from_z,
   input  logic [11:0] req_to_x,
   input  logic [12:0] req_to_height,
   input  logic [11:0] req_to_z,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_travel_time,
   input  logic        rsp_no_movement,
   input  logic        rsp_saturated,
   output int          fail_count,
   output int          pending_count
);

   localparam int FRAC = 16;

   typedef struct {
      logic [31:0] travel_time;
      logic        no_movement;
      logic        saturated;
   } walk_time_type;

   walk_time_type walk_times_due[$];
   logic [63:0]   half_roots [1:16];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   initial begin
      logic [63:0] r;
      r = int_sqrt(64'd1 << 61);
      for (int i = 1; i <= 16; i++) begin
         half_roots[i] = r;
         r = int_sqrt(r << 30);
      end
   end

   function automatic walk_time_type predict_walk_time(
      input logic [11:0] fx, input logic [12:0] fh, input logic [11:0] fz,
      input logic [11:0] tx, input logic [12:0] th, input logic [11:0] tz);
      walk_time_type w;
      longint        dh, sn;
      logic [63:0]   dx, dz, adh, h2, d2, hq, dq, num, a, p, n, m, x, y, t;
      int            s;
      w.travel_time = 0;
      w.no_movement = 0;
      w.saturated   = 0;
      dh  = longint'(th) - longint'(fh);
      dx  = (fx > tx) ? fx - tx : tx - fx;
      dz  = (fz > tz) ? fz - tz : tz - fz;
      adh = (dh < 0) ? -dh : dh;
      h2  = dx * dx + dz * dz;
      d2  = h2 + adh * adh;
      if (h2 == 0) begin
         w.no_movement = 1;
         return w;
      end
      hq  = int_sqrt(h2 << (2 * FRAC));
      dq  = int_sqrt(d2 << (2 * FRAC));
      sn  = dh * 20 * (longint'(1) << FRAC) + longint'(hq);
      num = (sn < 0) ? -sn : sn;
      a   = (num * 57344) / (5 * hq);
      if (a >= (64'd18 << 16)) begin
         w.travel_time = '1;
         w.saturated   = 1;
         return w;
      end
      p = (a * 94548) >> 16;
      n = p >> 16;
      m = 64'd1 << 30;
      for (int i = 1; i <= 16; i++)
         if (p[16-i]) m = (m * half_roots[i]) >> 30;
      x = dq * m;
      y = (x / 5) * 3 + ((x % 5) * 3) / 5;
      s = int'(n) - FRAC - 22;
      if (s >= 0) begin
         if (s >= 32 || y > (64'hFFFF_FFFF >> s)) begin
            w.travel_time = '1;
            w.saturated   = 1;
            return w;
         end
         t = y << s;
      end else begin
         t = y >> (-s);
         if (t > 64'hFFFF_FFFF) begin
            w.travel_time = '1;
            w.saturated   = 1;
            return w;
         end
      end
      w.travel_time = t[31:0];
      return w;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending_count = walk_times_due.size();

   always @(posedge clock) begin
      walk_time_type w;
      if (!reset) begin
         if (req_valid && !req_stall)
            walk_times_due.insert(walk_times_due.size(),
               predict_walk_time(req_from_x, req_from_height, req_from_z,
                                 req_to_x, req_to_height, req_to_z));
         if (rsp_valid && !rsp_stall) begin
            if (walk_times_due.size() == 0) begin
               report("unexpected transaction", rsp_travel_time, 32'd0);
            end else begin
               w = walk_times_due.pop_front();
               if (rsp_travel_time !== w.travel_time)
                  report("travel_time", rsp_travel_time, w.travel_time);
               if (rsp_no_movement !== w.no_movement)
                  report("no_movement", 32'(rsp_no_movement), 32'(w.no_movement));
               if (rsp_saturated !== w.saturated)
                  report("saturated", 32'(rsp_saturated), 32'(w.saturated));
            end
         end
      end
   end

endmodule

// ===== tb/sv/terrain_travel_time_cost_tb.sv =====
`timescale 1ns / 100ps

module terrain_travel_time_cost_tb;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_from_x;
   logic [12:0] req_from_height;
   logic [11:0] req_from_z;
   logic [11:0] req_to_x;
   logic [12:0] req_to_height;
   logic [11:0] req_to_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_travel_time;
   logic        rsp_no_movement;
   logic        rsp_saturated;

   int  fail_count;
   int  pending_count;
   int  cycle_count;
   int  results_seen;
   bit  no_gaps;     // burst stretch: neither side idles
   bit  long_hold_done;

   terrain_travel_time_cost dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_from_x      (req_from_x),
      .req_from_height (req_from_height),
      .req_from_z      (req_from_z),
      .req_to_x        (req_to_x),
      .req_to_height   (req_to_height),
      .req_to_z        (req_to_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_travel_time (rsp_travel_time),
      .rsp_no_movement (rsp_no_movement),
      .rsp_saturated   (rsp_saturated)
   );

   terrain_travel_time_cost_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_from_x      (req_from_x),
      .req_from_height (req_from_height),
      .req_from_z      (req_from_z),
      .req_to_x        (req_to_x),
      .req_to_height   (req_to_height),
      .req_to_z        (req_to_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_travel_time (rsp_travel_time),
      .rsp_no_movement (rsp_no_movement),
      .rsp_saturated   (rsp_saturated),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the pipe hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("terrain_travel_time_cost_tb NOT OK");
         $finish;
      end
   end

   // one transaction on req_: idle gap first, then hold valid until taken
   task automatic send_leg(input logic [11:0] fx, input logic [12:0] fh,
                           input logic [11:0] fz, input logic [11:0] tx,
                           input logic [12:0] th, input logic [11:0] tz);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1;
      req_from_x      <= fx;
      req_from_height <= fh;
      req_from_z      <= fz;
      req_to_x        <= tx;
      req_to_height   <= th;
      req_to_z        <= tz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // step to a nearby point to keep the slope moderate; it may still saturate
   function automatic logic [12:0] nudge(input logic [12:0] v, input int span,
                                         input logic [12:0] top);
      int r;
      r = int'(v) + $urandom_range(0, 2 * span) - span;
      if (r < 0) r = 0;
      if (r > int'(top)) r = int'(top);
      return r[12:0];
   endfunction

   // receiver: random hold-offs, plus one long hold to back the pipe up
   initial begin
      int hold;
      rsp_stall = 1;
      results_seen = 0;
      long_hold_done = 0;
      @(negedge reset);
      forever begin
         if (!long_hold_done && results_seen >= 60) begin
            hold = 300;
            long_hold_done = 1;
         end else begin
            hold = no_gaps ? 0 : $urandom_range(0, 13);
         end
         if (hold > 0) begin
            rsp_stall <= 1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_seen++;
      end
   end

   initial begin
      logic [11:0] fx, fz, tx, tz;
      logic [12:0] fh, th;
      int          waited;
      cycle_count     = 0;
      no_gaps         = 0;
      reset           = 1;
      req_valid       = 0;
      req_from_x      = 0;
      req_from_height = 0;
      req_from_z      = 0;
      req_to_x        = 0;
      req_to_height   = 0;
      req_to_z        = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: no movement (flat and with height change), extremes,
      // steep climbs and drops that saturate, gentle descent, flat walks
      send_leg(0, 0, 0, 0, 0, 0);
      send_leg(4095, 8191, 4095, 4095, 0, 4095);
      send_leg(100, 0, 200, 100, 8191, 200);
      send_leg(0, 0, 0, 4095, 0, 4095);
      send_leg(4095, 8191, 4095, 0, 8191, 0);
      send_leg(0, 0, 0, 4095, 8191, 4095);
      send_leg(4095, 8191, 4095, 0, 0, 0);
      send_leg(0, 0, 0, 1, 0, 0);
      send_leg(0, 0, 0, 0, 0, 1);
      send_leg(10, 0, 10, 11, 8191, 10);
      send_leg(10, 8191, 10, 11, 0, 10);
      send_leg(0, 1000, 0, 100, 995, 0);
      send_leg(0, 1000, 0, 100, 1100, 0);
      send_leg(0, 1000, 0, 100, 900, 0);
      send_leg(0, 0, 0, 3, 15, 4);
      send_leg(0, 20, 0, 3, 0, 4);
      send_leg(2048, 4096, 2048, 2047, 4096, 2049);
      send_leg(4095, 0, 0, 0, 8191, 4095);
      send_leg(0, 100, 0, 1, 105, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_gaps = ((i / 50) % 4 == 3);
         fx = 12'($urandom); fz = 12'($urandom); fh = 13'($urandom);
         case ($urandom_range(0, 9))
            0, 1: begin
               tx = 12'($urandom); tz = 12'($urandom); th = 13'($urandom);
            end
            2: begin
               tx = fx; tz = fz; th = 13'($urandom);
            end
            3: begin
               tx = 12'(nudge({1'b0, fx}, 2, 13'd4095));
               tz = 12'(nudge({1'b0, fz}, 2, 13'd4095));
               th = nudge(fh, 12, 13'd8191);
            end
            default: begin
               tx = 12'(nudge({1'b0, fx}, 200, 13'd4095));
               tz = 12'(nudge({1'b0, fz}, 200, 13'd4095));
               th = nudge(fh, 300, 13'd8191);
            end
         endcase
         send_leg(fx, fh, fz, tx, th, tz);
      end
      req_valid <= 0;
      no_gaps = 0;

      while (pending_count != 0) @(posedge clock);
      waited = 0;
      while (waited < 100) begin
         @(posedge clock);
         waited++;
      end
      if (fail_count == 0) begin
         $display("terrain_travel_time_cost_tb OK");
      end else begin
         $display("terrain_travel_time_cost_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== terrain_travel_time_cost.f =====
rtl/tttc_pkg.sv
rtl/tttc_sqrt_stage.sv
rtl/tttc_sqrt_pipe.sv
rtl/tttc_div_pipe.sv
rtl/terrain_travel_time_cost.sv
tb/sv/terrain_travel_time_cost_checker.sv
tb/sv/terrain_travel_time_cost_tb.sv
